// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Both expect clk_i and rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/lpet_pkg.sv =====
`default_nettype none

package lpet_pkg;

  // Field widths
  localparam int COEF_W         = 19;
  localparam int COORD_W        = 32;
  localparam int REQ_W          = 2;
  localparam int COEF_ONE_SHIFT = 16;

  // Datapath widths
  localparam int NUM_W     = 52;  // a*x + b*y + c*2^16, signed
  localparam int MAG_W     = NUM_W - 1;
  localparam int LO_W      = 26;  // low slice of |num| per multiply pass
  localparam int HI_W      = MAG_W - LO_W;
  localparam int DEN_W     = 38;  // a*a + b*b
  localparam int PROD_W    = COEF_W + MAG_W;  // |coef| * |num|
  localparam int MUL_A_W   = COEF_W + 1;
  localparam int MUL_B_W   = COORD_W + 1;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int QUOT_BITS = 34;  // quotient bits kept; larger values saturate anyway
  localparam int TOP_W     = PROD_W - QUOT_BITS;
  localparam int DIV_CNT_W = $clog2(QUOT_BITS);
  localparam int SUM_W     = COORD_W + 5;

  // Stream payload widths
  localparam int S_TDATA_W = 2 * COORD_W;
  localparam int S_TUSER_W = REQ_W;
  localparam int M_TDATA_W = 200;

  // Register reset values
  localparam logic [COEF_W-1:0] COEF_B_RST = COEF_W'(65536);

  typedef enum logic [2:0] {
    CFG_COEF_A       = 3'd0,
    CFG_COEF_B       = 3'd1,
    CFG_COEF_C       = 3'd2,
    CFG_INIT_START_X = 3'd3,
    CFG_INIT_START_Y = 3'd4,
    CFG_INIT_END_X   = 3'd5,
    CFG_INIT_END_Y   = 3'd6
  } cfg_idx_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_QUERY   = 2'd0,
    REQ_EXTEND  = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FIN
  } state_e;

  // Multiply pass order
  typedef enum logic [2:0] {
    MS_AX    = 3'd0,
    MS_BY    = 3'd1,
    MS_AA    = 3'd2,
    MS_BB    = 3'd3,
    MS_PA_LO = 3'd4,
    MS_PA_HI = 3'd5,
    MS_PB_LO = 3'd6,
    MS_PB_HI = 3'd7
  } mstep_e;

endpackage

`default_nettype wire

// ===== hdl/line_projection_extent_tracker.sv =====
// A general line takes the eight passes through the single 20x33 multiplier,
// then the 34-step radix-2 divider; a vertical line (b = 0) takes only the
// divider and a degenerate line (a = b = 0) neither. No new beat is taken
// until the last one has left the finish step.
// Reset: asynchronous, active low; registers take their reset values and
// the segment endpoints clear to the reset values of the init registers.
`default_nettype none
`include "assert_macros.svh"

module line_projection_extent_tracker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [2:0]                       cfg_idx_i,
  input  wire logic [31:0]                      cfg_wdata_i,
  // Point stream in
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // point_x [31:0], point_y [63:32]
  input  wire logic [lpet_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // req_type [1:0]
  input  wire logic [lpet_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // Result stream out
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // proj_x [31:0], proj_y [63:32], on_segment [64], seg_start_x [96:65],
  // seg_start_y [128:97], seg_end_x [160:129], seg_end_y [192:161],
  // div_fault [193], zero fill [199:194]
  output logic [lpet_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

  localparam int CW = lpet_pkg::COORD_W;
  localparam int AW = lpet_pkg::COEF_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] coef_a_q, coef_b_q;
  logic signed [CW-1:0] coef_c_q;
  logic signed [CW-1:0] init_sx_q, init_sy_q, init_ex_q, init_ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q  <= '0;
      coef_b_q  <= lpet_pkg::COEF_B_RST;
      coef_c_q  <= '0;
      init_sx_q <= '0;
      init_sy_q <= '0;
      init_ex_q <= '0;
      init_ey_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpet_pkg::CFG_COEF_A:       coef_a_q  <= cfg_wdata_i[AW-1:0];
        lpet_pkg::CFG_COEF_B:       coef_b_q  <= cfg_wdata_i[AW-1:0];
        lpet_pkg::CFG_COEF_C:       coef_c_q  <= cfg_wdata_i;
        lpet_pkg::CFG_INIT_START_X: init_sx_q <= cfg_wdata_i;
        lpet_pkg::CFG_INIT_START_Y: init_sy_q <= cfg_wdata_i;
        lpet_pkg::CFG_INIT_END_X:   init_ex_q <= cfg_wdata_i;
        lpet_pkg::CFG_INIT_END_Y:   init_ey_q <= cfg_wdata_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  lpet_pkg::state_e state_q, state_d;
  lpet_pkg::mstep_e step_q, step_d;

  logic s_acc;
  logic line_vert, line_zero;
  logic div_start, div_done;
  logic fin_go;
  logic out_valid_q, out_valid_d;

  assign line_vert = (coef_b_q == '0);
  assign line_zero = line_vert && (coef_a_q == '0);
  assign s_acc     = s_axis_tvalid && s_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      lpet_pkg::ST_IDLE: begin
        step_d = lpet_pkg::MS_AX;
        if (s_axis_tvalid) begin
          if (line_zero) begin
            state_d = lpet_pkg::ST_FIN;
          end else if (line_vert) begin
            state_d = lpet_pkg::ST_DSTART;
          end else begin
            state_d = lpet_pkg::ST_MUL;
          end
        end
      end
      lpet_pkg::ST_MUL: begin
        step_d = lpet_pkg::mstep_e'(step_q + 3'd1);
        if (step_q == lpet_pkg::MS_PB_HI) begin
          state_d = lpet_pkg::ST_DSTART;
        end
      end
      lpet_pkg::ST_DSTART: state_d = lpet_pkg::ST_DIV;
      lpet_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lpet_pkg::ST_FIN;
        end
      end
      lpet_pkg::ST_FIN: begin
        if (fin_go) begin
          state_d = lpet_pkg::ST_IDLE;
        end
      end
      default: state_d = lpet_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs; finish only once the result slot is free or draining
  always_comb begin
    s_axis_tready = (state_q == lpet_pkg::ST_IDLE);
    div_start     = (state_q == lpet_pkg::ST_DSTART);
    fin_go        = (state_q == lpet_pkg::ST_FIN) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpet_pkg::ST_IDLE;
      step_q  <= lpet_pkg::MS_AX;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: a*x, b*y, a*a, b*b, then |a|*|num| and |b|*|num|
  // in two slices each
  // ---------------------------------------------------------------------------
  logic [lpet_pkg::REQ_W-1:0]          req_q;
  logic signed [CW-1:0]                x_q, y_q;
  logic                                vert_q, zero_q;
  logic [lpet_pkg::NUM_W-1:0]          num_q, num_neg;
  logic [lpet_pkg::MAG_W-1:0]          mag_q;
  logic [lpet_pkg::DEN_W-1:0]          den_q;
  logic [lpet_pkg::PROD_W-1:0]         pa_q, pb_q, prod_ext;
  logic                                negx_q, negy_q;

  logic [AW-1:0]                       abs_a, abs_b;
  logic [CW-1:0]                       abs_c, neg_c;
  logic signed [lpet_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lpet_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lpet_pkg::MUL_P_W-1:0] prod;

  assign abs_a    = coef_a_q[AW-1] ? -coef_a_q : coef_a_q;
  assign abs_b    = coef_b_q[AW-1] ? -coef_b_q : coef_b_q;
  assign neg_c    = -coef_c_q;
  assign abs_c    = coef_c_q[CW-1] ? neg_c : coef_c_q;
  assign num_neg  = -num_q;
  assign prod_ext = {{(lpet_pkg::PROD_W - lpet_pkg::MUL_P_W){1'b0}}, prod};

  always_comb begin
    case (step_q)
      lpet_pkg::MS_AX: begin
        mul_a = {coef_a_q[AW-1], coef_a_q};
        mul_b = {x_q[CW-1], x_q};
      end
      lpet_pkg::MS_BY: begin
        mul_a = {coef_b_q[AW-1], coef_b_q};
        mul_b = {y_q[CW-1], y_q};
      end
      lpet_pkg::MS_AA: begin
        mul_a = {coef_a_q[AW-1], coef_a_q};
        mul_b = {{(lpet_pkg::MUL_B_W - AW){coef_a_q[AW-1]}}, coef_a_q};
      end
      lpet_pkg::MS_BB: begin
        mul_a = {coef_b_q[AW-1], coef_b_q};
        mul_b = {{(lpet_pkg::MUL_B_W - AW){coef_b_q[AW-1]}}, coef_b_q};
      end
      lpet_pkg::MS_PA_LO: begin
        mul_a = {1'b0, abs_a};
        mul_b = {{(lpet_pkg::MUL_B_W - lpet_pkg::LO_W){1'b0}}, mag_q[lpet_pkg::LO_W-1:0]};
      end
      lpet_pkg::MS_PA_HI: begin
        mul_a = {1'b0, abs_a};
        mul_b = {{(lpet_pkg::MUL_B_W - lpet_pkg::HI_W){1'b0}},
                 mag_q[lpet_pkg::MAG_W-1:lpet_pkg::LO_W]};
      end
      lpet_pkg::MS_PB_LO: begin
        mul_a = {1'b0, abs_b};
        mul_b = {{(lpet_pkg::MUL_B_W - lpet_pkg::LO_W){1'b0}}, mag_q[lpet_pkg::LO_W-1:0]};
      end
      default: begin
        mul_a = {1'b0, abs_b};
        mul_b = {{(lpet_pkg::MUL_B_W - lpet_pkg::HI_W){1'b0}},
                 mag_q[lpet_pkg::MAG_W-1:lpet_pkg::LO_W]};
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q  <= s_axis_tuser;
      x_q    <= s_axis_tdata[CW-1:0];
      y_q    <= s_axis_tdata[2*CW-1:CW];
      vert_q <= line_vert;
      zero_q <= line_zero;
      // Vertical line: x = -(c*2^16)/a, y passes through (zero y dividend)
      pa_q   <= {{(lpet_pkg::PROD_W - CW - lpet_pkg::COEF_ONE_SHIFT){1'b0}},
                 abs_c, {lpet_pkg::COEF_ONE_SHIFT{1'b0}}};
      pb_q   <= '0;
      den_q  <= {{(lpet_pkg::DEN_W - AW){1'b0}}, abs_a};
      negx_q <= coef_c_q[CW-1] ^ coef_a_q[AW-1];
      negy_q <= 1'b0;
    end else if (state_q == lpet_pkg::ST_MUL) begin
      case (step_q)
        lpet_pkg::MS_AX: begin
          num_q <= {{(lpet_pkg::NUM_W - CW - lpet_pkg::COEF_ONE_SHIFT){coef_c_q[CW-1]}},
                    coef_c_q, {lpet_pkg::COEF_ONE_SHIFT{1'b0}}} + prod[lpet_pkg::NUM_W-1:0];
        end
        lpet_pkg::MS_BY: num_q <= num_q + prod[lpet_pkg::NUM_W-1:0];
        lpet_pkg::MS_AA: begin
          den_q  <= prod[lpet_pkg::DEN_W-1:0];
          mag_q  <= num_q[lpet_pkg::NUM_W-1] ? num_neg[lpet_pkg::MAG_W-1:0]
                                              : num_q[lpet_pkg::MAG_W-1:0];
          negx_q <= coef_a_q[AW-1] ^ num_q[lpet_pkg::NUM_W-1];
          negy_q <= coef_b_q[AW-1] ^ num_q[lpet_pkg::NUM_W-1];
        end
        lpet_pkg::MS_BB:    den_q <= den_q + prod[lpet_pkg::DEN_W-1:0];
        lpet_pkg::MS_PA_LO: pa_q  <= prod_ext;
        lpet_pkg::MS_PA_HI: pa_q  <= pa_q + (prod_ext << lpet_pkg::LO_W);
        lpet_pkg::MS_PB_LO: pb_q  <= prod_ext;
        default:            pb_q  <= pb_q + (prod_ext << lpet_pkg::LO_W);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: both corrections share den = a*a + b*b (den = |a| for a vertical line)
  // ---------------------------------------------------------------------------
  logic [lpet_pkg::QUOT_BITS:0] quot_x, quot_y;

  lpet_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dvd_x_i  (pa_q),
    .dvd_y_i  (pb_q),
    .dsr_i    (den_q),
    .done_o   (div_done),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  // ---------------------------------------------------------------------------
  // Finish: apply correction, saturate, query and update endpoints
  // ---------------------------------------------------------------------------
  function automatic logic [CW-1:0] sat_coord(input logic [lpet_pkg::SUM_W-1:0] v);
    logic all_one, any_one;
    all_one = &v[lpet_pkg::SUM_W-1:CW-1];
    any_one = |v[lpet_pkg::SUM_W-1:CW-1];
    if (v[lpet_pkg::SUM_W-1] && !all_one) begin
      sat_coord = {1'b1, {(CW-1){1'b0}}};
    end else if (!v[lpet_pkg::SUM_W-1] && any_one) begin
      sat_coord = {1'b0, {(CW-1){1'b1}}};
    end else begin
      sat_coord = v[CW-1:0];
    end
  endfunction

  logic [lpet_pkg::SUM_W-1:0] base_x, base_y, qx_ext, qy_ext, sum_x, sum_y;
  logic signed [CW-1:0]       px, py, zero_px;
  logic signed [CW-1:0]       lo_x_q, lo_y_q, hi_x_q, hi_y_q;
  logic signed [CW-1:0]       lo_x_d, lo_y_d, hi_x_d, hi_y_d;
  logic                       on_seg;
  logic signed [CW-1:0]       proj_x_q, proj_y_q;
  logic                       on_seg_q, fault_q;

  always_comb begin
    base_x  = vert_q ? '0 : {{(lpet_pkg::SUM_W - CW){x_q[CW-1]}}, x_q};
    base_y  = {{(lpet_pkg::SUM_W - CW){y_q[CW-1]}}, y_q};
    qx_ext  = {{(lpet_pkg::SUM_W - lpet_pkg::QUOT_BITS - 1){1'b0}}, quot_x};
    qy_ext  = {{(lpet_pkg::SUM_W - lpet_pkg::QUOT_BITS - 1){1'b0}}, quot_y};
    sum_x   = negx_q ? base_x + qx_ext : base_x - qx_ext;
    sum_y   = negy_q ? base_y + qy_ext : base_y - qy_ext;
    // Degenerate line: x goes to the rail opposite the sign of c
    if (coef_c_q > 0) begin
      zero_px = {1'b1, {(CW-1){1'b0}}};
    end else if (coef_c_q < 0) begin
      zero_px = {1'b0, {(CW-1){1'b1}}};
    end else begin
      zero_px = '0;
    end
    px     = zero_q ? zero_px : sat_coord(sum_x);
    py     = zero_q ? y_q : sat_coord(sum_y);
    on_seg = (x_q >= lo_x_q) && (x_q <= hi_x_q);
  end

  always_comb begin
    lo_x_d = lo_x_q;
    lo_y_d = lo_y_q;
    hi_x_d = hi_x_q;
    hi_y_d = hi_y_q;
    if (fin_go) begin
      case (req_q)
        lpet_pkg::REQ_EXTEND: begin
          if (vert_q) begin
            // Vertical line: grow along y
            if (y_q < lo_y_q) begin
              lo_x_d = px;
              lo_y_d = y_q;
            end
            if (y_q > hi_y_q) begin
              hi_x_d = px;
              hi_y_d = y_q;
            end
          end else begin
            if (px < lo_x_q) begin
              lo_x_d = px;
              lo_y_d = py;
            end
            if (px > hi_x_q) begin
              hi_x_d = px;
              hi_y_d = py;
            end
          end
        end
        lpet_pkg::REQ_RESTART: begin
          lo_x_d = init_sx_q;
          lo_y_d = init_sy_q;
          hi_x_d = init_ex_q;
          hi_y_d = init_ey_q;
        end
        default: ;  // query and the unused code leave the segment alone
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_x_q      <= '0;
      lo_y_q      <= '0;
      hi_x_q      <= '0;
      hi_y_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lo_x_q      <= lo_x_d;
      lo_y_q      <= lo_y_d;
      hi_x_q      <= hi_x_d;
      hi_y_q      <= hi_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result beat; endpoints only move when this slot is free or draining
  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      proj_x_q <= px;
      proj_y_q <= py;
      on_seg_q <= on_seg;
      fault_q  <= zero_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lpet_pkg::M_TDATA_W - 6*CW - 2){1'b0}}, fault_q,
                          hi_y_q, hi_x_q, lo_y_q, lo_x_q, on_seg_q, proj_y_q, proj_x_q};

  `ASSERT_CLK(a_div_done_in_div, div_done |-> (state_q == lpet_pkg::ST_DIV),
              "divider finished outside the divide phase")
  `ASSERT_CLK(a_result_from_fin, $rose(out_valid_q) |-> ($past(state_q) == lpet_pkg::ST_FIN),
              "result beat raised without a finish step")
  `ASSERT_CLK(a_seg_moves_on_fin,
              (!$stable(lo_x_q) || !$stable(hi_x_q) || !$stable(lo_y_q) || !$stable(hi_y_q))
              |-> ($past(state_q) == lpet_pkg::ST_FIN),
              "segment endpoints changed outside a finish step")

endmodule

`default_nettype wire

// ===== hdl/lpet_div.sv =====
`default_nettype none
`include "assert_macros.svh"

module lpet_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [lpet_pkg::PROD_W-1:0]      dvd_x_i,
  input  wire logic [lpet_pkg::PROD_W-1:0]      dvd_y_i,
  input  wire logic [lpet_pkg::DEN_W-1:0]       dsr_i,
  output logic                                  done_o,
  output logic [lpet_pkg::QUOT_BITS:0]          quot_x_o,
  output logic [lpet_pkg::QUOT_BITS:0]          quot_y_o
);

  localparam int DW = lpet_pkg::DEN_W;
  localparam int QB = lpet_pkg::QUOT_BITS;
  localparam int TW = lpet_pkg::TOP_W;

  logic                    busy_q, busy_d;
  logic [lpet_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]           dsr_q;
  logic [DW-1:0]           rem_q   [2];
  logic [QB-1:0]           dvd_q   [2];
  logic [QB-1:0]           quo_q   [2];
  logic [1:0]              cap_q;

  logic [lpet_pkg::PROD_W-1:0] dvd_s [2];
  logic [DW-1:0]           rem_init [2];
  logic [DW-1:0]           rem_step [2];
  logic [DW:0]             trial    [2];
  logic [DW:0]             diff     [2];
  logic [1:0]              cap_s;
  logic [1:0]              fits;
  logic                    last_step;

  assign dvd_s[0] = dvd_x_i;
  assign dvd_s[1] = dvd_y_i;
  assign last_step = (cnt_q == lpet_pkg::DIV_CNT_W'(QB - 1));
  assign done_o    = busy_q && last_step;

  // Two restoring lanes sharing one divisor, one quotient bit per cycle each.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cap_s[l]    = ({{(DW - TW){1'b0}}, dvd_s[l][lpet_pkg::PROD_W-1:QB]} >= dsr_i);
      rem_init[l] = cap_s[l] ? '0 : {{(DW - TW){1'b0}}, dvd_s[l][lpet_pkg::PROD_W-1:QB]};
      trial[l]    = {rem_q[l], dvd_q[l][QB-1]};
      diff[l]     = trial[l] - {1'b0, dsr_q};
      fits[l]     = (trial[l] >= {1'b0, dsr_q});
      rem_step[l] = fits[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= dsr_i;
      cap_q <= cap_s;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_init[l];
        dvd_q[l] <= dvd_s[l][QB-1:0];
        quo_q[l] <= '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_step[l];
        dvd_q[l] <= {dvd_q[l][QB-2:0], 1'b0};
        quo_q[l] <= {quo_q[l][QB-2:0], fits[l]};
      end
    end
  end

  // A quotient past the kept range reads as 2^QB, enough to saturate.
  assign quot_x_o = cap_q[0] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_q[0]};
  assign quot_y_o = cap_q[1] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_q[1]};

  `ASSERT_NEVER(a_div_start_busy, start_i && busy_q, "divider restarted while busy")
  `ASSERT_CLK(a_div_done_ends, done_o |=> !busy_q, "divider still busy after done")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the block does not define; it must behave as a query.
  localparam logic [lpet_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Projection corrections are capped at 2^40 before the subtraction.
  localparam logic [127:0] CORR_CAP = 128'd1 << 40;

  // Receiver hold-off used once to back the block up into its input.
  localparam int HOLD_OFF_CYCLES = 400;

  // Cycles to let pass after the last result, well above the block's latency.
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [lpet_pkg::REQ_W-1:0]   req;
    logic [lpet_pkg::COORD_W-1:0] x;
    logic [lpet_pkg::COORD_W-1:0] y;
  } point_beat_t;

  typedef struct {
    logic [lpet_pkg::COORD_W-1:0] proj_x;
    logic [lpet_pkg::COORD_W-1:0] proj_y;
    logic                         on_seg;
    logic [lpet_pkg::COORD_W-1:0] start_x;
    logic [lpet_pkg::COORD_W-1:0] start_y;
    logic [lpet_pkg::COORD_W-1:0] end_x;
    logic [lpet_pkg::COORD_W-1:0] end_y;
    logic                         fault;
  } track_res_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [2:0]                     cfg_idx_i     = '0;
  logic [31:0]                    cfg_wdata_i   = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [lpet_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [lpet_pkg::S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [lpet_pkg::M_TDATA_W-1:0] m_axis_tdata;

  initial forever #4 clk_i = ~clk_i;

  line_projection_extent_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // point_x [31:0], point_y [63:32]
    .s_axis_tuser  (s_axis_tuser),   // req_type [1:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // proj_x, proj_y, on_segment, endpoints, div_fault
  );

  // ---------------------------------------------------------------------------
  // Predictor state: line registers and the tracked segment, at block widths.
  // ---------------------------------------------------------------------------
  logic signed [lpet_pkg::COEF_W-1:0]  line_a    = '0;
  logic signed [lpet_pkg::COEF_W-1:0]  line_b    = lpet_pkg::COEF_B_RST;
  logic signed [lpet_pkg::COORD_W-1:0] line_c    = '0;
  logic signed [lpet_pkg::COORD_W-1:0] span_sx   = '0;
  logic signed [lpet_pkg::COORD_W-1:0] span_sy   = '0;
  logic signed [lpet_pkg::COORD_W-1:0] span_ex   = '0;
  logic signed [lpet_pkg::COORD_W-1:0] span_ey   = '0;
  logic signed [lpet_pkg::COORD_W-1:0] seg_lo_x  = '0;
  logic signed [lpet_pkg::COORD_W-1:0] seg_lo_y  = '0;
  logic signed [lpet_pkg::COORD_W-1:0] seg_hi_x  = '0;
  logic signed [lpet_pkg::COORD_W-1:0] seg_hi_y  = '0;

  point_beat_t point_queue[$];   // beats waiting for the driver
  track_res_t  exp_results[$];   // predicted results, oldest first
  point_beat_t drv_beat;

  logic no_idle   = 1'b0;   // both sides run flat out while set
  logic hold_go   = 1'b0;   // asks the receiver for its one long hold-off
  logic hold_done = 1'b0;
  int   hold_cnt  = 0;

  int n_errors   = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_faults   = 0;
  int n_on_seg   = 0;
  int n_settings = 0;

  function automatic logic [lpet_pkg::COORD_W-1:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // trunc(m * n / d) with d > 0, magnitude capped at CORR_CAP; the wide product needs 128 bits.
  function automatic longint scaled_corr(input longint m, input longint n, input longint d);
    logic [63:0]  mm;
    logic [63:0]  nn;
    logic [127:0] q;
    mm = (m < 0) ? -m : m;
    nn = (n < 0) ? -n : n;
    q = ({64'd0, mm} * {64'd0, nn}) / {64'd0, d[63:0]};
    if (q > CORR_CAP) q = CORR_CAP;
    return ((m < 0) != (n < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Project one point, report span membership, then update the segment.
  function automatic track_res_t track_point(input point_beat_t p);
    track_res_t                          r;
    longint                              a, b, c, x, y, num, den, pxl, pyl;
    logic signed [lpet_pkg::COORD_W-1:0] px, py, ys;
    a  = longint'(line_a);
    b  = longint'(line_b);
    c  = longint'(line_c);
    ys = p.y;
    x  = longint'($signed(p.x));
    y  = longint'(ys);
    r.fault  = 1'b0;
    r.on_seg = (x >= seg_lo_x) && (x <= seg_hi_x);
    if (b == 0) begin
      pyl = y;
      if (a == 0) begin
        // Zero line: saturate x against the sign of c.
        r.fault = 1'b1;
        pxl = (c > 0) ? -64'sd2147483648 : ((c < 0) ? 64'sd2147483647 : 64'sd0);
      end else begin
        pxl = -((c <<< lpet_pkg::COEF_ONE_SHIFT) / a);
      end
    end else begin
      num = a * x + b * y + (c <<< lpet_pkg::COEF_ONE_SHIFT);
      den = a * a + b * b;
      pxl = x - scaled_corr(a, num, den);
      pyl = y - scaled_corr(b, num, den);
    end
    px = sat32(pxl);
    py = sat32(pyl);

    if (p.req == lpet_pkg::REQ_EXTEND) begin
      if (b == 0) begin
        // Vertical line: the endpoint whose y is passed moves.
        if (ys < seg_lo_y) begin seg_lo_x = px; seg_lo_y = ys; end
        if (ys > seg_hi_y) begin seg_hi_x = px; seg_hi_y = ys; end
      end else begin
        if (px < seg_lo_x) begin seg_lo_x = px; seg_lo_y = py; end
        if (px > seg_hi_x) begin seg_hi_x = px; seg_hi_y = py; end
      end
    end else if (p.req == lpet_pkg::REQ_RESTART) begin
      seg_lo_x = span_sx;
      seg_lo_y = span_sy;
      seg_hi_x = span_ex;
      seg_hi_y = span_ey;
    end

    r.proj_x  = px;
    r.proj_y  = py;
    r.start_x = seg_lo_x;
    r.start_y = seg_lo_y;
    r.end_x   = seg_hi_x;
    r.end_y   = seg_hi_y;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued points, hold each beat until accepted, predict on
  // acceptance. Idle about 29 times in 100 unless no_idle is set.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    logic go;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_results.push_back(track_point(drv_beat));
        n_sent++;
      end
      // Load the next beat only when the slot is empty or just drained.
      if (!s_axis_tvalid || s_axis_tready) begin
        go = (point_queue.size() != 0) && (no_idle || ($urandom_range(99) >= 29));
        if (go) begin
          drv_beat     = point_queue.pop_front();
          s_axis_tdata <= {drv_beat.y, drv_beat.x};
          s_axis_tuser <= drv_beat.req;
        end
        s_axis_tvalid <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls, plus one long hold-off counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt      <= HOLD_OFF_CYCLES;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every accepted result beat with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon_proc
    track_res_t got;
    track_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.proj_x  = m_axis_tdata[31:0];
      got.proj_y  = m_axis_tdata[63:32];
      got.on_seg  = m_axis_tdata[64];
      got.start_x = m_axis_tdata[96:65];
      got.start_y = m_axis_tdata[128:97];
      got.end_x   = m_axis_tdata[160:129];
      got.end_y   = m_axis_tdata[192:161];
      got.fault   = m_axis_tdata[193];
      n_checked++;
      if (got.fault) n_faults++;
      if (got.on_seg) n_on_seg++;
      if (exp_results.size() == 0) begin
        report_mismatch("result beat with no point outstanding");
      end else begin
        want = exp_results.pop_front();
        check_field("proj_x",      got.proj_x,  want.proj_x);
        check_field("proj_y",      got.proj_y,  want.proj_y);
        check_field("on_segment",  32'(got.on_seg), 32'(want.on_seg));
        check_field("seg_start_x", got.start_x, want.start_x);
        check_field("seg_start_y", got.start_y, want.start_y);
        check_field("seg_end_x",   got.end_x,   want.end_x);
        check_field("seg_end_y",   got.end_y,   want.end_y);
        check_field("div_fault",   32'(got.fault), 32'(want.fault));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] fx(input int whole);
    return whole <<< 16;
  endfunction

  // Mostly coordinates near the origin, some anywhere, some at the rails.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1, 2:    return $urandom();
      default: return $urandom_range(0, 32'h0FA0_0000) - 32'h07D0_0000;
    endcase
  endfunction

  task automatic add_point(input logic [lpet_pkg::REQ_W-1:0] req, input logic [31:0] x,
                           input logic [31:0] y);
    point_beat_t p;
    p.req = req;
    p.x   = x;
    p.y   = y;
    point_queue.push_back(p);
  endtask

  // Write one register while the block is idle; mirror it in the predictor.
  task automatic write_cfg(input lpet_pkg::cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      lpet_pkg::CFG_COEF_A:       line_a  = val[lpet_pkg::COEF_W-1:0];
      lpet_pkg::CFG_COEF_B:       line_b  = val[lpet_pkg::COEF_W-1:0];
      lpet_pkg::CFG_COEF_C:       line_c  = val;
      lpet_pkg::CFG_INIT_START_X: span_sx = val;
      lpet_pkg::CFG_INIT_START_Y: span_sy = val;
      lpet_pkg::CFG_INIT_END_X:   span_ex = val;
      lpet_pkg::CFG_INIT_END_Y:   span_ey = val;
      default: ;
    endcase
  endtask

  task automatic set_line(input int a, input int b, input logic [31:0] c);
    write_cfg(lpet_pkg::CFG_COEF_A, a);
    write_cfg(lpet_pkg::CFG_COEF_B, b);
    write_cfg(lpet_pkg::CFG_COEF_C, c);
    n_settings++;
  endtask

  task automatic set_span(input logic [31:0] sx, input logic [31:0] sy,
                          input logic [31:0] ex, input logic [31:0] ey);
    write_cfg(lpet_pkg::CFG_INIT_START_X, sx);
    write_cfg(lpet_pkg::CFG_INIT_START_Y, sy);
    write_cfg(lpet_pkg::CFG_INIT_END_X, ex);
    write_cfg(lpet_pkg::CFG_INIT_END_Y, ey);
  endtask

  // Block until every queued point is accepted and every result is back.
  task automatic wait_idle(input int settle);
    do @(posedge clk_i);
    while (point_queue.size() != 0 || s_axis_tvalid || exp_results.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic random_setting();
    int a, b;
    a = int'($urandom_range(0, 262144)) - 131072;
    b = int'($urandom_range(0, 262144)) - 131072;
    case ($urandom_range(7))
      0: begin b = 0; if (a == 0) a = 65536; end            // vertical
      1: begin a = 0; b = 0; end                            // zero line
      2: a = 0;                                             // horizontal
      3: begin
        a = $urandom_range(1) ? 131072 : -131072;
        b = $urandom_range(1) ? 131072 : -131072;
      end
      4: a = int'($urandom_range(0, 8)) - 4;                // near-horizontal
      default: ;
    endcase
    set_line(a, b, rand_coord());
    set_span(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Well-formed runs: usually a restart, then mostly extends and queries, with a rare
  // mid-run restart and the odd unused code thrown in.
  task automatic random_phase(input int n);
    int                         pick;
    logic [lpet_pkg::REQ_W-1:0] req;
    if ($urandom_range(3) != 0) add_point(lpet_pkg::REQ_RESTART, rand_coord(), rand_coord());
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 10)      req = lpet_pkg::REQ_RESTART;
      else if (pick < 60) req = lpet_pkg::REQ_EXTEND;
      else if (pick < 95) req = lpet_pkg::REQ_QUERY;
      else                req = REQ_UNUSED;
      add_point(req, rand_coord(), rand_coord());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset line y = 0 with both endpoints at the origin: rails on both coordinates.
    add_point(lpet_pkg::REQ_EXTEND, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(lpet_pkg::REQ_EXTEND, 32'h8000_0000, 32'h7FFF_FFFF);
    add_point(lpet_pkg::REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
    add_point(REQ_UNUSED, 32'h0001_2345, 32'hFFFF_FFFF);
    add_point(lpet_pkg::REQ_RESTART, 32'h0000_0001, 32'h0000_0001);
    wait_idle(8);

    // Tilted line 0.6x + 0.8y + 3 = 0: restart, extend both ways, query.
    set_line(39322, 52429, fx(3));
    set_span(fx(-10), fx(2), fx(10), fx(-3));
    add_point(lpet_pkg::REQ_RESTART, 32'h0000_0000, 32'h0000_0000);
    add_point(lpet_pkg::REQ_EXTEND, fx(20), fx(5));
    add_point(lpet_pkg::REQ_EXTEND, fx(-30), fx(-7));
    add_point(lpet_pkg::REQ_QUERY, fx(5), fx(1));
    wait_idle(8);

    // Vertical line: extend above and below the span in y.
    set_line(-65536, 0, fx(7));
    add_point(lpet_pkg::REQ_RESTART, fx(1), fx(0));
    add_point(lpet_pkg::REQ_EXTEND, fx(3), fx(40));
    add_point(lpet_pkg::REQ_EXTEND, fx(-3), fx(-40));
    add_point(lpet_pkg::REQ_QUERY, fx(7), fx(2));
    wait_idle(8);

    // Zero line with c positive, negative and zero.
    set_line(0, 0, 32'h0000_0001);
    add_point(lpet_pkg::REQ_EXTEND, fx(9), fx(-50));
    add_point(lpet_pkg::REQ_QUERY, fx(-9), fx(50));
    wait_idle(8);
    set_line(0, 0, 32'hFFFF_FFFF);
    add_point(lpet_pkg::REQ_EXTEND, fx(2), fx(60));
    wait_idle(8);
    set_line(0, 0, 32'h0000_0000);
    add_point(lpet_pkg::REQ_QUERY, fx(0), fx(0));
    wait_idle(8);

    // Coefficient and coordinate extremes.
    set_line(131072, -131072, 32'h8000_0000);
    set_span(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(lpet_pkg::REQ_RESTART, 32'h0000_0000, 32'h0000_0000);
    add_point(lpet_pkg::REQ_EXTEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(lpet_pkg::REQ_EXTEND, 32'h8000_0000, 32'h8000_0000);
    add_point(lpet_pkg::REQ_QUERY, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle(8);
    set_line(-131072, 1, 32'h7FFF_FFFF);
    add_point(lpet_pkg::REQ_EXTEND, 32'h8000_0000, 32'h7FFF_FFFF);
    add_point(lpet_pkg::REQ_EXTEND, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle(8);

    // Random phases, each with a fresh setting.
    for (int k = 0; k < 6; k++) begin
      random_setting();
      case (k)
        2: begin
          // No idling on either side for the whole phase.
          @(posedge clk_i);
          no_idle <= 1'b1;
          random_phase(70);
          wait_idle(8);
          no_idle <= 1'b0;
        end
        3: begin
          // Stall the receiver long enough to back up into the input.
          random_phase(70);
          @(posedge clk_i);
          hold_go <= 1'b1;
          wait_idle(8);
        end
        4: begin
          // Sender pauses mid-phase until everything is back.
          random_phase(35);
          wait_idle(0);
          random_phase(35);
          wait_idle(8);
        end
        default: begin
          random_phase(70);
          wait_idle(8);
        end
      endcase
    end

    wait_idle(TAIL_CYCLES);
    if (exp_results.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", exp_results.size()));

    $display("Covered %0d points over %0d line settings: general, vertical, zero and extreme lines.",
             n_sent, n_settings);
    $display("Checked %0d result beats (%0d div faults, %0d on segment), %0d mismatches.",
             n_checked, n_faults, n_on_seg, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", exp_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
